FILE: rtl/core/fqlk_pkg.sv
package fqlk_pkg;

  localparam int NUM_RESOURCES = 16;
  localparam int QUEUE_DEPTH   = 8;
  localparam int TASK_ID_BITS  = 8;

  // Port field widths
  localparam int OP_W      = 2;
  localparam int TASK_IN_W = 8;
  localparam int RES_IN_W  = 4;
  localparam int WAITERS_W = 4;
  localparam int STATUS_W  = 2;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  // Internal widths
  localparam int TASK_W  = TASK_ID_BITS;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int RES_AW  = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam int ROW_W   = QUEUE_DEPTH * TASK_W;
  localparam int WORD_W  = ROW_W + CNT_W;

  typedef logic [TASK_W-1:0]                   task_t;
  typedef logic [QUEUE_DEPTH-1:0][TASK_W-1:0]  row_t;
  typedef logic [CNT_W-1:0]                    cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_REQUEST = 2'd0,
    OP_RELEASE = 2'd1,
    OP_QUERY   = 2'd2,
    OP_SPARE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_MATCH = 2'd2
  } status_t;

  // Outcome of one queue operation
  typedef struct packed {
    logic                  is_master;
    status_t               status;
    logic [WAITERS_W-1:0]  waiters;
    logic                  wr_en;
  } result_t;

endpackage

FILE: rtl/core/fqlk_ram.sv
module fqlk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/fqlk_row_update.sv
module fqlk_row_update (
  input  fqlk_pkg::op_t     op,
  input  fqlk_pkg::task_t   task_id,
  input  logic              res_ok,
  input  fqlk_pkg::row_t    row,
  input  fqlk_pkg::cnt_t    cnt,
  output fqlk_pkg::row_t    row_next,
  output fqlk_pkg::cnt_t    cnt_next,
  output fqlk_pkg::result_t res
);
  import fqlk_pkg::*;

  logic [QUEUE_DEPTH-1:0] match;
  logic [QUEUE_DEPTH-1:0] below_hit;
  logic                   found;
  logic                   full;

  // Flag entries that hold the task within the live part of the queue
  always_comb begin
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      match[j] = (CNT_W'(j) < cnt) && (row[j] == task_id);
    end
  end

  // Mark every slot at or above the first match; those shift down on release
  always_comb begin
    below_hit[0] = match[0];
    for (int j = 1; j < QUEUE_DEPTH; j++) begin
      below_hit[j] = below_hit[j-1] | match[j];
    end
  end

  assign found = |match;
  assign full  = (cnt == CNT_W'(QUEUE_DEPTH));

  // Build the new row and count
  always_comb begin
    row_next   = row;
    cnt_next   = cnt;
    res.status = ST_DONE;
    res.wr_en  = 1'b0;
    if (!res_ok) begin
      cnt_next = '0;
      case (op)
        OP_REQUEST: res.status = ST_FULL;
        OP_RELEASE: res.status = ST_NO_MATCH;
        default:    res.status = ST_DONE;
      endcase
    end else begin
      case (op)
        OP_REQUEST: begin
          if (full) begin
            res.status = ST_FULL;
          end else begin
            for (int j = 0; j < QUEUE_DEPTH; j++) begin
              if (CNT_W'(j) == cnt) row_next[j] = task_id;
            end
            cnt_next  = cnt + CNT_W'(1);
            res.wr_en = 1'b1;
          end
        end
        OP_RELEASE: begin
          if (!found) begin
            res.status = ST_NO_MATCH;
          end else begin
            for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
              if (below_hit[j]) row_next[j] = row[j+1];
            end
            cnt_next  = cnt - CNT_W'(1);
            res.wr_en = 1'b1;
          end
        end
        default: ;
      endcase
    end
    res.is_master = (cnt_next != '0) && (row_next[0] == task_id);
    res.waiters   = WAITERS_W'(cnt_next);
  end

endmodule

FILE: rtl/core/fifo_resource_lock_queue.sv
// FIFO resource lock queue.
// One ordered queue of task IDs is kept for each resource; the task at the
// head is the master. Commands arrive on the s_ stream (request, release,
// query) and each produces exactly one transaction on the m_ stream with the
// master flag, a status code and the queue length after the command.
// Each resource's queue and its length live in one word of a synchronous
// RAM. A command is accepted in the idle state and its row is read; in the
// execute state the row is updated, written back and the result registered.
// A new command is taken only after the previous one has left the execute
// state, since the RAM row is read and then written back.
// The next command may be accepted while a result still waits in the
// output register; if the receiver stalls longer, the block holds the
// looked-up row in the execute cycle and stops accepting until the output
// register frees up.
// Reset clears a valid bit for every resource row, so all queues read as
// empty at once; no clearing pass is needed.
module fifo_resource_lock_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [1:0] op, [9:2] task_id, [13:10] resource_id, [15:14] zero
  input  logic [fqlk_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] is_master, [2:1] status, [6:3] waiters, [7] zero
  output logic [fqlk_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import fqlk_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  logic [OP_W-1:0]      in_op;
  logic [TASK_IN_W-1:0] in_task;
  logic [RES_IN_W-1:0]  in_res;

  op_t                  op;
  task_t                task_id;
  logic                 res_ok;
  logic [RES_AW-1:0]    addr;
  logic [NUM_RESOURCES-1:0] row_valid;
  logic                 row_live;

  logic                 accept;
  logic                 exec_go;
  logic [WORD_W-1:0]    rd_word;
  logic [WORD_W-1:0]    wr_word;
  row_t                 row;
  row_t                 row_next;
  cnt_t                 cnt;
  cnt_t                 cnt_next;
  result_t              res;

  assign in_op   = s_tdata[1:0];
  assign in_task = s_tdata[9:2];
  assign in_res  = s_tdata[13:10];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign exec_go  = (state == S_EXEC) && (!m_tvalid || m_tready);

  // Latch the command for the execute cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= op_t'(in_op);
      task_id <= TASK_W'(in_task);
      res_ok  <= (int'(in_res) < NUM_RESOURCES);
      addr    <= RES_AW'(in_res);
    end
  end

  // Sequence accept and execute
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_EXEC;
      S_EXEC: if (exec_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Rows never written read as empty queues
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (exec_go && res.wr_en) begin
      row_valid[addr] <= 1'b1;
    end
  end

  assign row_live = row_valid[addr];

  fqlk_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_RESOURCES)
  ) u_queue_ram (
    .clk     (clk),
    .wr_en   (exec_go && res.wr_en),
    .wr_addr (addr),
    .wr_data (wr_word),
    .rd_en   (accept),
    .rd_addr (RES_AW'(in_res)),
    .rd_data (rd_word)
  );

  assign row     = row_t'(rd_word[ROW_W-1:0]);
  assign cnt     = row_live ? rd_word[WORD_W-1:ROW_W] : '0;
  assign wr_word = {cnt_next, row_next};

  fqlk_row_update u_row_update (
    .op       (op),
    .task_id  (task_id),
    .res_ok   (res_ok),
    .row      (row),
    .cnt      (cnt),
    .row_next (row_next),
    .cnt_next (cnt_next),
    .res      (res)
  );

  // Output register: load on execute, drop valid when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      m_tdata <= {1'b0, res.waiters, res.status, res.is_master};
    end
  end

  // Checks
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EXEC))
    else $error("accepted command did not enter execute");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (exec_go && res.wr_en) |-> (cnt_next <= CNT_W'(QUEUE_DEPTH)))
    else $error("queue length written beyond depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (exec_go && res_ok && res.status == ST_FULL) |-> (cnt == CNT_W'(QUEUE_DEPTH)))
    else $error("full status on a queue that is not full");

  a_master_nonempty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (m_tdata[6:3] != '0 || QUEUE_DEPTH > 15))
    else $error("master reported on an empty queue");

  a_no_write_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && m_tvalid && !m_tready) |=> (state == S_EXEC))
    else $error("execute left while output register was blocked");

endmodule
